/* rtl/core/wb_temperature_gain_table_defines.svh */
// Assertion macros shared by the white-balance gain table RTL.
`ifndef WB_TEMPERATURE_GAIN_TABLE_DEFINES_SVH
`define WB_TEMPERATURE_GAIN_TABLE_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define WBTG_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wbtg assertion failed");

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define WBTG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wbtg assertion failed");

`endif

/* rtl/core/wbtg_pkg.sv */
// ---------------------------------------------------------------------------
// wbtg_pkg
// Widths, types and the build-time gain factor ROM of the white-balance
// gain table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package wbtg_pkg;

    localparam int TABLE_ENTRIES = 76;
    localparam int FRAC_BITS     = 12;
    localparam int IN_W          = 7;
    localparam int CAL_W         = 16;
    localparam int FAC_W         = 4 + FRAC_BITS;
    localparam int PROD_W        = FAC_W + CAL_W;
    localparam int OUT_W         = 24;
    localparam int TH_W          = 7;
    localparam int REM_W         = PROD_W + 1;
    localparam int N_W           = PROD_W + FRAC_BITS;
    localparam int CMP_W         = 10;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int TDATA_IN_W    = 8;
    localparam int TDATA_OUT_W   = ((3 * OUT_W + TH_W + 7) / 8) * 8;

    // Configuration register indexes.
    localparam logic [1:0] REG_CAL_RED   = 2'd0;
    localparam logic [1:0] REG_CAL_GREEN = 2'd1;
    localparam logic [1:0] REG_CAL_BLUE  = 2'd2;

    localparam logic [CAL_W-1:0] CAL_RESET = CAL_W'(4096);

    typedef logic [TABLE_ENTRIES-1:0][2:0][FAC_W-1:0] rom_t;

    // One channel of the divider pipeline.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [OUT_W-1:0] quo;
        logic             sat;
    } lane_t;

    // Pipeline control shared by all stages.
    typedef struct packed {
        logic en;
    } ctl_t;

    // Fixed-point fit arithmetic, evaluated at elaboration only.
    localparam int QB = 28;
    localparam logic [63:0] ONE = 64'd1 << QB;
    localparam logic [63:0] DEC = 64'd10000000000;

    // Unsigned quotient by shift and subtract.
    function automatic logic [63:0] udiv(logic [63:0] a, logic [63:0] b);
        logic [63:0] q;
        logic [64:0] r;
        q = 64'd0;
        r = 65'd0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], a[i]};
            if (r >= {1'b0, b}) begin
                r = r - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
        return ((a * (b >> 14)) >> 14) + ((a * (b & 64'h3FFF)) >> QB);
    endfunction

    function automatic logic [63:0] from_dec(logic [63:0] n);
        logic [63:0] q;
        q = udiv(n, DEC);
        return (q << QB) + udiv(((n - q * DEC) << QB) + (DEC >> 1), DEC);
    endfunction

    function automatic logic [63:0] ln_mant(logic [63:0] m);
        logic [63:0] z, z2, term, sum;
        z = udiv((m - ONE) << QB, m + ONE);
        z2 = qmul(z, z);
        term = z;
        sum = 64'd0;
        for (int n = 1; n < 40; n += 2) begin
            sum = sum + udiv(term, 64'(n));
            term = qmul(term, z2);
        end
        return 64'd2 * sum;
    endfunction

    function automatic logic [63:0] qln(logic [63:0] xin);
        logic [63:0] x, k;
        x = xin;
        k = 64'd0;
        while (x >= 64'd2 * ONE) begin
            x = x >> 1;
            k = k + 64'd1;
        end
        return k * ln_mant(64'd2 * ONE) + ln_mant(x);
    endfunction

    function automatic logic [63:0] qexp(logic [63:0] y);
        logic [63:0] ln2, k, r, sum, term;
        ln2 = ln_mant(64'd2 * ONE);
        k = udiv(y, ln2);
        r = y - k * ln2;
        sum = ONE;
        term = ONE;
        for (int n = 1; n <= 20; n++) begin
            term = udiv(qmul(term, r), 64'(n));
            sum = sum + term;
        end
        return sum << k;
    endfunction

    function automatic logic signed [63:0] pow_fit(logic [63:0] a_coef,
                                                   logic [63:0] a_exp,
                                                   logic [63:0] x);
        logic signed [63:0] lr;
        lr = $signed(qln(a_coef)) - $signed(qmul(a_exp, qln(x << QB)));
        if (lr <= 0)
            return $signed(ONE);
        if (lr > $signed(64'd6 * ONE))
            return $signed(64'd256 * ONE);
        return $signed(qexp(lr));
    endfunction

    function automatic logic signed [63:0] log_fit(logic [63:0] c1,
                                                   logic [63:0] c2,
                                                   logic [63:0] x);
        return $signed(qmul(c1, qln(x << QB))) - $signed(c2);
    endfunction

    function automatic logic [FAC_W-1:0] to_factor(logic signed [63:0] vin);
        logic signed [63:0] v;
        logic [63:0] u, f, fmax;
        v = vin;
        fmax = (64'd16 << FRAC_BITS) - 64'd1;
        if (v < $signed(ONE))
            v = $signed(ONE);
        if (v > $signed(64'd255 * ONE))
            v = $signed(64'd255 * ONE);
        u = v;
        f = udiv((64'd255 << (FRAC_BITS + QB)) + (u >> 1), u);
        if (f > fmax)
            f = fmax;
        return f[FAC_W-1:0];
    endfunction

    function automatic rom_t build_rom();
        rom_t rom;
        logic [63:0] red_a, red_e, grn_c1, grn_c2, grn_a, grn_e, blu_c1, blu_c2, t;
        logic signed [63:0] r, g, b;
        red_a  = from_dec(64'd3296987274460);
        red_e  = from_dec(64'd1332047592);
        grn_c1 = from_dec(64'd994708025861);
        grn_c2 = from_dec(64'd1611195681661);
        grn_a  = from_dec(64'd2881221695283);
        grn_e  = from_dec(64'd755148492);
        blu_c1 = from_dec(64'd1385177312231);
        blu_c2 = from_dec(64'd3050447927307);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            t = 64'd25 + 64'(i);
            r = (t <= 64'd66) ? $signed(64'd255 * ONE) : pow_fit(red_a, red_e, t - 64'd60);
            g = (t <= 64'd66) ? log_fit(grn_c1, grn_c2, t) : pow_fit(grn_a, grn_e, t - 64'd60);
            if (t >= 64'd66)
                b = $signed(64'd255 * ONE);
            else if (t <= 64'd19)
                b = $signed(ONE);
            else
                b = log_fit(blu_c1, blu_c2, t - 64'd10);
            rom[i][0] = to_factor(r);
            rom[i][1] = to_factor(g);
            rom[i][2] = to_factor(b);
        end
        return rom;
    endfunction

    localparam rom_t GAIN_ROM = build_rom();

endpackage
`default_nettype wire

/* rtl/core/wbtg_front.sv */
// ---------------------------------------------------------------------------
// wbtg_front
// Lookup, calibration multiply and minimum search: three register stages
// that prepare the divider lanes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module wbtg_front
    import wbtg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctl_t              ctl,
    input  wire logic              in_valid,
    input  wire logic [IN_W-1:0]   temp_index,
    input  wire logic [CAL_W-1:0]  cal_red,
    input  wire logic [CAL_W-1:0]  cal_green,
    input  wire logic [CAL_W-1:0]  cal_blue,
    output logic                   out_valid,
    output lane_t [2:0]            out_lane,
    output logic [REM_W-1:0]       out_div,
    output logic [TH_W-1:0]        out_th
);

    localparam logic [CMP_W-1:0] IDX_MAX = CMP_W'(TABLE_ENTRIES - 1);

    logic                  va_reg, vb_reg, vc_reg;
    logic [2:0][FAC_W-1:0] fac_reg;
    logic [2:0][PROD_W-1:0] prod_reg;
    lane_t [2:0]           lane_reg;
    logic [REM_W-1:0]      div_reg;
    logic [TH_W-1:0]       tha_reg, thb_reg, thc_reg;

    logic [CMP_W-1:0]      idx_wide;
    logic [IDX_W-1:0]      idx;
    logic [PROD_W-1:0]     mn;
    logic [REM_W-1:0]      div_next;
    logic [2:0][N_W-1:0]   num;
    logic [2:0][REM_W-1:0] rem0;

    // Clamp the index to the last table entry.
    always_comb
    begin
        idx_wide = (CMP_W'(temp_index) > IDX_MAX) ? IDX_MAX : CMP_W'(temp_index);
        idx = idx_wide[IDX_W-1:0];
    end

    // Minimum product; a zero minimum divides by 2^(2*FRAC_BITS) instead,
    // which yields the product truncated to Q12.
    always_comb
    begin
        mn = prod_reg[0];
        if (prod_reg[1] < mn)
            mn = prod_reg[1];
        if (prod_reg[2] < mn)
            mn = prod_reg[2];
        div_next = (mn == '0) ? (REM_W'(1) << (2 * FRAC_BITS)) : REM_W'(mn);
        for (int c = 0; c < 3; c++)
        begin
            num[c]  = {prod_reg[c], {FRAC_BITS{1'b0}}};
            rem0[c] = REM_W'(num[c] >> OUT_W);
        end
    end

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    // Payload of the three stages.
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            fac_reg     <= GAIN_ROM[idx];
            tha_reg     <= TH_W'(idx_wide + CMP_W'(25));
            prod_reg[0] <= PROD_W'(fac_reg[0] * cal_red);
            prod_reg[1] <= PROD_W'(fac_reg[1] * cal_green);
            prod_reg[2] <= PROD_W'(fac_reg[2] * cal_blue);
            thb_reg     <= tha_reg;
            for (int c = 0; c < 3; c++)
            begin
                lane_reg[c].rem <= rem0[c];
                lane_reg[c].quo <= num[c][OUT_W-1:0];
                lane_reg[c].sat <= (rem0[c] >= div_next);
            end
            div_reg <= div_next;
            thc_reg <= thb_reg;
        end
    end

    assign out_valid = vc_reg;
    assign out_lane  = lane_reg;
    assign out_div   = div_reg;
    assign out_th    = thc_reg;

endmodule
`default_nettype wire

/* rtl/core/wbtg_div.sv */
// ---------------------------------------------------------------------------
// wbtg_div
// Pipelined restoring divider: one quotient bit per stage for all three
// channels, followed by saturation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module wbtg_div
    import wbtg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctl_t              ctl,
    input  wire logic              in_valid,
    input  wire lane_t [2:0]       in_lane,
    input  wire logic [REM_W-1:0]  in_div,
    input  wire logic [TH_W-1:0]   in_th,
    output logic                   out_valid,
    output logic [2:0][OUT_W-1:0]  out_gain,
    output logic [TH_W-1:0]        out_th
);

    logic                  v_reg   [OUT_W];
    lane_t [2:0]           lane_reg[OUT_W];
    logic [REM_W-1:0]      div_reg [OUT_W];
    logic [TH_W-1:0]       th_reg  [OUT_W];

    for (genvar k = 0; k < OUT_W; k++)
    begin : g_stage
        logic                  vi;
        lane_t [2:0]           li;
        logic [REM_W-1:0]      di;
        logic [TH_W-1:0]       ti;
        lane_t [2:0]           lane_next;
        logic [2:0][REM_W:0]   trial;

        if (k == 0)
        begin : g_first
            assign vi = in_valid;
            assign li = in_lane;
            assign di = in_div;
            assign ti = in_th;
        end
        else
        begin : g_rest
            assign vi = v_reg[k-1];
            assign li = lane_reg[k-1];
            assign di = div_reg[k-1];
            assign ti = th_reg[k-1];
        end

        // Shift in the next dividend bit and subtract where it fits.
        always_comb
        begin
            for (int c = 0; c < 3; c++)
            begin
                trial[c] = {li[c].rem, li[c].quo[OUT_W-1]};
                lane_next[c].sat = li[c].sat;
                if (trial[c] >= {1'b0, di})
                begin
                    lane_next[c].rem = REM_W'(trial[c] - {1'b0, di});
                    lane_next[c].quo = {li[c].quo[OUT_W-2:0], 1'b1};
                end
                else
                begin
                    lane_next[c].rem = trial[c][REM_W-1:0];
                    lane_next[c].quo = {li[c].quo[OUT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (ctl.en)
                v_reg[k] <= vi;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                lane_reg[k] <= lane_next;
                div_reg[k]  <= di;
                th_reg[k]   <= ti;
            end
        end
    end

    // Saturate quotients that would not fit Q12.12.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
            out_gain[c] = lane_reg[OUT_W-1][c].sat ? {OUT_W{1'b1}}
                                                   : lane_reg[OUT_W-1][c].quo;
    end

    assign out_valid = v_reg[OUT_W-1];
    assign out_th    = th_reg[OUT_W-1];

endmodule
`default_nettype wire

/* rtl/core/wb_temperature_gain_table.sv */
// ---------------------------------------------------------------------------
// wb_temperature_gain_table
// White-balance gains by color temperature, normalized to the smallest.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one temperature index per item (kelvin = 2500 + 100 * index,
//   indexes above 75 serve 10000 K). m_axis returns one item per input with
//   the red, green and blue gains in Q12.12 and the temperature served.
//   The cfg channel writes the Q4.12 calibration gains (index 0 red, 1 green,
//   2 blue; other indexes are ignored); cfg_ready is always high. Write them
//   only while no item is in flight.
//   Lookup, multiply and minimum take three stages, the restoring divider
//   one stage per quotient bit (24).
//   Throughput is one item per cycle. When m_axis_tready is low the whole
//   pipeline holds while an item waits at the output, and s_axis_tready
//   drops with it; nothing is lost or repeated.
//   Reset empties the pipeline and sets all calibration gains to 1.0.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "wb_temperature_gain_table_defines.svh"
module wb_temperature_gain_table
    import wbtg_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [6:0] temp_index, [7] zero
    input  wire logic [TDATA_IN_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [23:0] gain_red, [47:24] gain_green, [71:48] gain_blue,
    // [78:72] temp_hundreds, [79] zero
    output logic [TDATA_OUT_W-1:0]      m_axis_tdata,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [CAL_W-1:0]       cfg_data
);

    logic [CAL_W-1:0]     cal_red_reg, cal_green_reg, cal_blue_reg;
    ctl_t                 ctl;
    logic                 front_valid;
    lane_t [2:0]          front_lane;
    logic [REM_W-1:0]     front_div;
    logic [TH_W-1:0]      front_th;
    logic [2:0][OUT_W-1:0] gain;
    logic [TH_W-1:0]      temp_hundreds;

    // Calibration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_red_reg   <= CAL_RESET;
            cal_green_reg <= CAL_RESET;
            cal_blue_reg  <= CAL_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CAL_RED:   cal_red_reg   <= cfg_data;
                REG_CAL_GREEN: cal_green_reg <= cfg_data;
                REG_CAL_BLUE:  cal_blue_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // The pipeline advances unless a finished item waits at the output.
    assign ctl.en        = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = ctl.en;

    wbtg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .in_valid   (s_axis_tvalid),
        .temp_index (s_axis_tdata[IN_W-1:0]),
        .cal_red    (cal_red_reg),
        .cal_green  (cal_green_reg),
        .cal_blue   (cal_blue_reg),
        .out_valid  (front_valid),
        .out_lane   (front_lane),
        .out_div    (front_div),
        .out_th     (front_th)
    );

    wbtg_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .in_valid   (front_valid),
        .in_lane    (front_lane),
        .in_div     (front_div),
        .in_th      (front_th),
        .out_valid  (m_axis_tvalid),
        .out_gain   (gain),
        .out_th     (temp_hundreds)
    );

    assign m_axis_tdata = TDATA_OUT_W'({temp_hundreds, gain[2], gain[1], gain[0]});

    // Assertions.
    `WBTG_ASSERT_NOW(a_ready_follows_output, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    `WBTG_ASSERT_NOW(a_temp_in_range, m_axis_tvalid, (temp_hundreds >= TH_W'(25)) && (temp_hundreds <= TH_W'(100)))
    `WBTG_ASSERT_NEXT(a_cal_holds, !cfg_valid, $stable(cal_red_reg) && $stable(cal_green_reg) && $stable(cal_blue_reg))

endmodule
`default_nettype wire
